[hdl/bcu_pkg.sv]
// Shared types, widths, codes and helper functions of the bilinear cell upsampler.
// No dependencies; every other file refers to this package by scoped names.
package bcu_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 8;
	localparam int STEP_W    = 4;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int CFG_IDX_W = 2;

	// multiplier operands carry one extra bit so unsigned magnitudes stay positive
	localparam int OP_W      = NUM_WIDTH + 1;
	localparam int PROD_W    = 2 * OP_W;
	localparam int AREA_W    = 2 * NUM_WIDTH;
	localparam int QUO_W     = NUM_WIDTH;
	localparam int DIVD_W    = AREA_W + QUO_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);
	// weighted sum: value times two magnitudes, four terms, plus headroom
	localparam int ACC_W     = 3 * NUM_WIDTH + 4;
	localparam int SH_W      = PROD_W - FRAC_BITS;

	typedef logic signed [NUM_WIDTH-1:0] num_t;

	localparam num_t SCALE_ONE = {{(NUM_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_X     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_Y     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SCALE = CFG_IDX_W'(2);

	typedef struct packed {
		num_t x_low;
		num_t x_high;
		num_t y_low;
		num_t y_high;
		num_t val_ll;
		num_t val_lh;
		num_t val_hl;
		num_t val_hh;
	} in_item_t;

	typedef struct packed {
		num_t point_x;
		num_t point_y;
		num_t point_value;
		logic degenerate;
		logic last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MAG,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_AREA,
		ST_AREA_W,
		ST_PT,
		ST_MAC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SCALE,
		ST_SAT,
		ST_OUT
	} state_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] s);
		logic [STEP_W-1:0] r;
		if (s == '0) begin
			r = STEP_W'(1);
		end else if (s > STEP_W'(MAX_STEPS)) begin
			r = STEP_W'(MAX_STEPS);
		end else begin
			r = s;
		end
		return r;
	endfunction

	// saturate a shifted product to the number width
	function automatic num_t sat_num(input logic signed [SH_W-1:0] v);
		logic [SH_W-NUM_WIDTH:0] upper;
		num_t r;
		upper = v[SH_W-1:NUM_WIDTH-1];
		if ((&upper) || !(|upper)) begin
			r = v[NUM_WIDTH-1:0];
		end else if (v[SH_W-1]) begin
			r = {1'b1, {(NUM_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(NUM_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[hdl/bcu_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on bcu_pkg for operand and product widths.
module bcu_mul (
	input  logic                                clk,
	input  logic signed [bcu_pkg::OP_W-1:0]     a,
	input  logic signed [bcu_pkg::OP_W-1:0]     b,
	output logic signed [bcu_pkg::PROD_W-1:0]   p_s1
);

	// register every product; result is usable in the cycle after issue
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

[hdl/bcu_div.sv]
// Shared restoring divider: one quotient bit per cycle, 32 steps per division.
// Depends on bcu_pkg for widths. The caller guarantees the quotient fits QUO_W bits.
module bcu_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bcu_pkg::DIVD_W-1:0]        dividend,
	input  logic [bcu_pkg::AREA_W-1:0]        divisor,
	output logic                              done,
	output logic [bcu_pkg::QUO_W-1:0]         quotient
);

	logic [bcu_pkg::AREA_W-1:0]    rem_q;
	logic [bcu_pkg::AREA_W-1:0]    dsr_q;
	logic [bcu_pkg::QUO_W-1:0]     lo_q;
	logic                          busy_q;
	logic                          done_q;
	logic [bcu_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [bcu_pkg::AREA_W+1:0]    diff;
	logic                          ge;

	// trial subtract of the divisor from the shifted partial remainder
	assign diff = {1'b0, rem_q, lo_q[bcu_pkg::QUO_W-1]} - {2'b00, dsr_q};
	assign ge   = !diff[bcu_pkg::AREA_W+1];

	assign done     = done_q;
	assign quotient = lo_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bcu_pkg::DIV_CNT_W'(bcu_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift; low dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[bcu_pkg::DIVD_W-1:bcu_pkg::QUO_W];
			lo_q  <= dividend[bcu_pkg::QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[bcu_pkg::AREA_W-1:0]
				: {rem_q[bcu_pkg::AREA_W-2:0], lo_q[bcu_pkg::QUO_W-1]};
			lo_q  <= {lo_q[bcu_pkg::QUO_W-2:0], ge};
		end
	end

endmodule

[hdl/bilinear_cell_upsampler.sv]
// Bilinear cell upsampler top level: sequencer, datapath registers and output register.
// Depends on bcu_pkg, bcu_mul and bcu_div.
//
// One cell is taken at a time; cell_stall stays high until its last point has been
// loaded into the output register. Per cell the block first does its setup (two
// step-size divisions on the shared divider, then the area product), then per point
// the multiply-accumulate of the four weighted terms on the single shared 33x33
// multiplier, the area division, and scaling and output. A zero-area cell skips the
// multiply-accumulate, division and scaling for each point. The output register lets
// the next cell enter while the last point still waits on point_stall.
module bilinear_cell_upsampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  bcu_pkg::in_item_t                   cell_data,
	output logic                                point_valid,
	input  logic                                point_stall,
	output bcu_pkg::out_item_t                  point_data,
	input  logic                                cfg_we,
	input  logic [bcu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcu_pkg::NUM_WIDTH-1:0]       cfg_data
);

	// multiply-accumulate phase codes within one weight term
	localparam logic [1:0] PH_WEIGHT = 2'd0;
	localparam logic [1:0] PH_LO     = 2'd1;
	localparam logic [1:0] PH_HI     = 2'd2;
	localparam logic [1:0] PH_ACC    = 2'd3;

	localparam int NW = bcu_pkg::NUM_WIDTH;

	bcu_pkg::state_t state_q, state_d;

	// configuration
	logic [bcu_pkg::STEP_W-1:0] steps_x_q, steps_y_q;
	bcu_pkg::num_t              scale_q;

	// cell and per-cell values
	bcu_pkg::in_item_t          cell_q;
	logic [bcu_pkg::STEP_W-1:0] sx_q, sy_q;
	logic signed [NW:0]         w_q, h_q;
	logic signed [NW:0]         w_abs, h_abs;
	logic [NW-1:0]              wmag_q, hmag_q;
	logic                       wneg_q, hneg_q;
	logic                       degen_q;
	logic [NW-1:0]              dxm_q, dym_q;
	bcu_pkg::num_t              dx_q, dy_q;
	logic [bcu_pkg::AREA_W-1:0] area_q;

	// per-point values
	logic [bcu_pkg::IDX_W-1:0]  k_q, l_q;
	logic [NW-1:0]              a0_q, a1_q, b0_q, b1_q;
	bcu_pkg::num_t              px_q, py_q;
	logic [3:0]                 mstep_q;
	logic [NW-1:0]              hi_q;
	logic signed [bcu_pkg::ACC_W-1:0] acc_q;
	logic [bcu_pkg::ACC_W-1:0]  acc_abs;
	logic signed [bcu_pkg::ACC_W-1:0] prod_ext;
	bcu_pkg::num_t              q_q;
	bcu_pkg::num_t              val_q;

	// output register
	logic                       out_valid_q;
	bcu_pkg::out_item_t         out_q;

	// shared units
	logic signed [bcu_pkg::OP_W-1:0]   mul_a, mul_b;
	logic signed [bcu_pkg::PROD_W-1:0] mul_p;
	logic                              div_start, div_done;
	logic [bcu_pkg::DIVD_W-1:0]        div_dividend;
	logic [bcu_pkg::AREA_W-1:0]        div_divisor;
	logic [bcu_pkg::QUO_W-1:0]         div_quot;

	logic                accept;
	logic                out_load;
	logic                row_end, last_pt;
	logic [1:0]          term, phase;
	bcu_pkg::num_t       val_sel;
	logic [NW-1:0]       a_sel, b_sel;
	logic signed [bcu_pkg::SH_W-1:0] scaled;

	bcu_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	bcu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign cell_stall  = (state_q != bcu_pkg::ST_IDLE);
	assign accept      = cell_valid && !cell_stall;
	assign point_valid = out_valid_q;
	assign point_data  = out_q;
	assign out_load    = (state_q == bcu_pkg::ST_OUT) && (!out_valid_q || !point_stall);

	// position in the run
	assign row_end = ({1'b0, l_q} == sy_q - 1'b1);
	assign last_pt = row_end && ({1'b0, k_q} == sx_q - 1'b1);

	// term select: ll uses a0 b0, hl a1 b0, lh a0 b1, hh a1 b1
	assign term  = mstep_q[3:2];
	assign phase = mstep_q[1:0];
	always_comb begin
		case (term)
			2'd0:    val_sel = cell_q.val_ll;
			2'd1:    val_sel = cell_q.val_hl;
			2'd2:    val_sel = cell_q.val_lh;
			default: val_sel = cell_q.val_hh;
		endcase
	end
	assign a_sel = term[0] ? a1_q : a0_q;
	assign b_sel = term[1] ? b1_q : b0_q;

	assign w_abs    = w_q[NW] ? -w_q : w_q;
	assign h_abs    = h_q[NW] ? -h_q : h_q;
	assign acc_abs  = acc_q[bcu_pkg::ACC_W-1] ? -acc_q : acc_q;
	assign prod_ext = {{(bcu_pkg::ACC_W-bcu_pkg::PROD_W){mul_p[bcu_pkg::PROD_W-1]}}, mul_p};
	assign scaled   = mul_p[bcu_pkg::PROD_W-1:bcu_pkg::FRAC_BITS];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and shared unit operands
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = {{bcu_pkg::AREA_W{1'b0}}, wmag_q};
		div_divisor  = {{(bcu_pkg::AREA_W-bcu_pkg::STEP_W){1'b0}}, sx_q};
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			bcu_pkg::ST_IDLE: begin
				if (cell_valid) state_d = bcu_pkg::ST_PREP;
			end
			bcu_pkg::ST_PREP: state_d = bcu_pkg::ST_MAG;
			bcu_pkg::ST_MAG:  state_d = bcu_pkg::ST_DX_GO;
			bcu_pkg::ST_DX_GO: begin
				div_start = 1'b1;
				state_d   = bcu_pkg::ST_DX_WAIT;
			end
			bcu_pkg::ST_DX_WAIT: begin
				if (div_done) state_d = bcu_pkg::ST_DY_GO;
			end
			bcu_pkg::ST_DY_GO: begin
				div_start    = 1'b1;
				div_dividend = {{bcu_pkg::AREA_W{1'b0}}, hmag_q};
				div_divisor  = {{(bcu_pkg::AREA_W-bcu_pkg::STEP_W){1'b0}}, sy_q};
				state_d      = bcu_pkg::ST_DY_WAIT;
			end
			bcu_pkg::ST_DY_WAIT: begin
				if (div_done) state_d = bcu_pkg::ST_AREA;
			end
			bcu_pkg::ST_AREA: begin
				mul_a   = {1'b0, wmag_q};
				mul_b   = {1'b0, hmag_q};
				state_d = bcu_pkg::ST_AREA_W;
			end
			bcu_pkg::ST_AREA_W: state_d = bcu_pkg::ST_PT;
			bcu_pkg::ST_PT: begin
				state_d = degen_q ? bcu_pkg::ST_OUT : bcu_pkg::ST_MAC;
			end
			bcu_pkg::ST_MAC: begin
				case (phase)
					PH_WEIGHT: begin
						mul_a = {1'b0, a_sel};
						mul_b = {1'b0, b_sel};
					end
					PH_LO: begin
						mul_a = {val_sel[NW-1], val_sel};
						mul_b = {1'b0, mul_p[NW-1:0]};
					end
					PH_HI: begin
						mul_a = {val_sel[NW-1], val_sel};
						mul_b = {1'b0, hi_q};
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
				if (mstep_q == 4'hF) state_d = bcu_pkg::ST_DIV_GO;
			end
			bcu_pkg::ST_DIV_GO: begin
				div_start    = 1'b1;
				div_dividend = acc_abs[bcu_pkg::DIVD_W-1:0];
				div_divisor  = area_q;
				state_d      = bcu_pkg::ST_DIV_WAIT;
			end
			bcu_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = bcu_pkg::ST_SCALE;
			end
			bcu_pkg::ST_SCALE: begin
				mul_a   = {q_q[NW-1], q_q};
				mul_b   = {scale_q[NW-1], scale_q};
				state_d = bcu_pkg::ST_SAT;
			end
			bcu_pkg::ST_SAT: state_d = bcu_pkg::ST_OUT;
			bcu_pkg::ST_OUT: begin
				if (out_load) state_d = last_pt ? bcu_pkg::ST_IDLE : bcu_pkg::ST_PT;
			end
			default: state_d = bcu_pkg::ST_IDLE;
		endcase
	end

	// configuration registers; writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_x_q <= bcu_pkg::STEP_W'(4);
			steps_y_q <= bcu_pkg::STEP_W'(4);
			scale_q   <= bcu_pkg::SCALE_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				bcu_pkg::CFG_STEPS_X:     steps_x_q <= cfg_data[bcu_pkg::STEP_W-1:0];
				bcu_pkg::CFG_STEPS_Y:     steps_y_q <= cfg_data[bcu_pkg::STEP_W-1:0];
				bcu_pkg::CFG_VALUE_SCALE: scale_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			l_q         <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !point_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bcu_pkg::ST_AREA_W: begin
					k_q <= '0;
					l_q <= '0;
				end
				bcu_pkg::ST_PT:  mstep_q <= '0;
				bcu_pkg::ST_MAC: mstep_q <= mstep_q + 1'b1;
				bcu_pkg::ST_OUT: begin
					if (out_load) begin
						if (row_end) begin
							l_q <= '0;
							k_q <= k_q + 1'b1;
						end else begin
							l_q <= l_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q <= cell_data;
			sx_q   <= bcu_pkg::clamp_steps(steps_x_q);
			sy_q   <= bcu_pkg::clamp_steps(steps_y_q);
		end
		case (state_q)
			bcu_pkg::ST_PREP: begin
				w_q <= {cell_q.x_high[NW-1], cell_q.x_high} - {cell_q.x_low[NW-1], cell_q.x_low};
				h_q <= {cell_q.y_high[NW-1], cell_q.y_high} - {cell_q.y_low[NW-1], cell_q.y_low};
			end
			bcu_pkg::ST_MAG: begin
				wneg_q  <= w_q[NW];
				hneg_q  <= h_q[NW];
				wmag_q  <= w_abs[NW-1:0];
				hmag_q  <= h_abs[NW-1:0];
				degen_q <= (w_q == '0) || (h_q == '0);
			end
			bcu_pkg::ST_DX_WAIT: begin
				if (div_done) begin
					dxm_q <= div_quot;
					dx_q  <= wneg_q ? -div_quot : div_quot;
				end
			end
			bcu_pkg::ST_DY_WAIT: begin
				if (div_done) begin
					dym_q <= div_quot;
					dy_q  <= hneg_q ? -div_quot : div_quot;
				end
			end
			bcu_pkg::ST_AREA_W: begin
				area_q <= mul_p[bcu_pkg::AREA_W-1:0];
				a1_q   <= '0;
				a0_q   <= wmag_q;
				b1_q   <= '0;
				b0_q   <= hmag_q;
				px_q   <= cell_q.x_low;
				py_q   <= cell_q.y_low;
			end
			bcu_pkg::ST_PT: begin
				acc_q <= '0;
				val_q <= '0;
			end
			bcu_pkg::ST_MAC: begin
				case (phase)
					PH_LO:  hi_q  <= mul_p[2*NW-1:NW];
					PH_HI:  acc_q <= acc_q + prod_ext;
					PH_ACC: acc_q <= acc_q + {prod_ext[bcu_pkg::ACC_W-NW-1:0], {NW{1'b0}}};
					default: ;
				endcase
			end
			bcu_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					q_q <= acc_q[bcu_pkg::ACC_W-1] ? -div_quot : div_quot;
				end
			end
			bcu_pkg::ST_SAT: val_q <= bcu_pkg::sat_num(scaled);
			bcu_pkg::ST_OUT: begin
				if (out_load) begin
					out_q.point_x     <= px_q;
					out_q.point_y     <= py_q;
					out_q.point_value <= val_q;
					out_q.degenerate  <= degen_q;
					out_q.last        <= last_pt;
					// advance weights and coordinates to the next point
					if (row_end) begin
						a1_q <= a1_q + dxm_q;
						a0_q <= a0_q - dxm_q;
						px_q <= px_q + dx_q;
						b1_q <= '0;
						b0_q <= hmag_q;
						py_q <= cell_q.y_low;
					end else begin
						b1_q <= b1_q + dym_q;
						b0_q <= b0_q - dym_q;
						py_q <= py_q + dy_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
